### rtl/scalar_kalman_adc_smoother_core_macros.svh
// Assertion macros shared by the scalar Kalman smoother RTL
`ifndef SCALAR_KALMAN_ADC_SMOOTHER_CORE_MACROS_SVH
`define SCALAR_KALMAN_ADC_SMOOTHER_CORE_MACROS_SVH

// same-cycle implication, disabled during reset
`define SKAS_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define SKAS_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/skas_pkg.sv
// Shared constants, codes and control types of the scalar Kalman smoother
package skas_pkg;

	localparam int ADC_BITS_DEF = 12;
	localparam int ADC_BITS_MAX = 16;
	localparam int SAMPLE_W     = 12;
	localparam int FRAC_EST     = 16;
	localparam int GAIN_FRAC    = 24;
	localparam int GAIN_W       = 25;
	localparam int NOISE_W      = 32;
	localparam int THR_W        = 12;
	localparam int WEIGHT_W     = 16;
	localparam int MUL_A_W      = 32;
	localparam int MUL_B_W      = 25;
	localparam int PROD_W       = 57;
	localparam int CMP_W        = 33;
	localparam int DIV_STEPS    = GAIN_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam int CFG_IDX_W    = 2;
	localparam int CFG_DATA_W   = 32;

	localparam logic [GAIN_W-1:0]   ONE_GAIN = 25'h100_0000;
	localparam logic [NOISE_W-1:0]  PROCESS_NOISE_RST     = 32'd1678;
	localparam logic [NOISE_W-1:0]  MEASUREMENT_NOISE_RST = 32'd83886080;
	localparam logic [THR_W-1:0]    JUMP_THRESHOLD_RST    = 12'd10;
	localparam logic [WEIGHT_W-1:0] BLEND_WEIGHT_RST      = 16'd25035;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PROCESS_NOISE,
		REG_MEASUREMENT_NOISE,
		REG_JUMP_THRESHOLD,
		REG_BLEND_WEIGHT
	} cfg_reg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PREP,
		ST_BLEND,
		ST_DIVIDE,
		ST_GAIN,
		ST_VAR,
		ST_COMMIT,
		ST_OUTPUT
	} state_t;

	typedef enum logic [1:0] {
		MUL_OLD,
		MUL_SW,
		MUL_GAIN,
		MUL_VAR
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     prep;
		logic     acc_load;
		logic     mul_en;
		mul_sel_t mul_sel;
		logic     blend_add;
		logic     div_step;
		logic     corr_load;
		logic     commit;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		logic div_done;
	} status_t;

endpackage

### rtl/skas_ctrl.sv
// Sequencer of the scalar Kalman smoother: handshakes and step commands
`include "scalar_kalman_adc_smoother_core_macros.svh"

module skas_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               sample_valid,
	output logic               sample_stall,
	output logic               result_valid,
	input  logic               result_stall,
	input  skas_pkg::status_t  status,
	output skas_pkg::cmd_t     cmd
);

	skas_pkg::state_t state_q, state_d;
	logic             res_valid_q;
	logic             out_free;

	assign out_free     = !res_valid_q || !result_stall;
	assign result_valid = res_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= skas_pkg::ST_IDLE;
			res_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				res_valid_q <= 1'b1;
			end else if (!result_stall) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.mul_sel  = skas_pkg::MUL_OLD;
		sample_stall = 1'b1;
		case (state_q)
			skas_pkg::ST_IDLE: begin
				sample_stall = 1'b0;
				if (sample_valid) begin
					cmd.load = 1'b1;
					state_d  = skas_pkg::ST_PREP;
				end
			end
			skas_pkg::ST_PREP: begin
				cmd.prep    = 1'b1;
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = skas_pkg::MUL_OLD;
				state_d     = skas_pkg::ST_BLEND;
			end
			skas_pkg::ST_BLEND: begin
				cmd.acc_load = 1'b1;
				cmd.mul_en   = 1'b1;
				cmd.mul_sel  = skas_pkg::MUL_SW;
				state_d      = skas_pkg::ST_DIVIDE;
			end
			skas_pkg::ST_DIVIDE: begin
				cmd.div_step  = 1'b1;
				cmd.blend_add = 1'b1;
				if (status.div_done) begin
					state_d = skas_pkg::ST_GAIN;
				end
			end
			skas_pkg::ST_GAIN: begin
				cmd.mul_en  = 1'b1;
				cmd.mul_sel = skas_pkg::MUL_GAIN;
				state_d     = skas_pkg::ST_VAR;
			end
			skas_pkg::ST_VAR: begin
				cmd.corr_load = 1'b1;
				cmd.mul_en    = 1'b1;
				cmd.mul_sel   = skas_pkg::MUL_VAR;
				state_d       = skas_pkg::ST_COMMIT;
			end
			skas_pkg::ST_COMMIT: begin
				cmd.commit = 1'b1;
				state_d    = skas_pkg::ST_OUTPUT;
			end
			skas_pkg::ST_OUTPUT: begin
				// hold until the result register is free
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = skas_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = skas_pkg::ST_IDLE;
			end
		endcase
	end

	`SKAS_ASSERT_NEXT(a_accept_starts_prep, sample_valid && !sample_stall, state_q == skas_pkg::ST_PREP, "accepted request did not start processing")
	`SKAS_ASSERT_IMPL(a_no_result_overwrite, cmd.out_load, !res_valid_q || !result_stall, "result overwritten while stalled")
	`SKAS_ASSERT_NEXT(a_commit_then_output, cmd.commit, state_q == skas_pkg::ST_OUTPUT, "commit not followed by output step")

endmodule

### rtl/skas_datapath.sv
// Datapath of the scalar Kalman smoother: registers, multiplier, gain divider
`include "scalar_kalman_adc_smoother_core_macros.svh"

module skas_datapath #(
	parameter int ADC_BITS = skas_pkg::ADC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_valid,
	input  logic [skas_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [skas_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic [skas_pkg::SAMPLE_W-1:0]       sample,
	output logic [skas_pkg::SAMPLE_W-1:0]       filtered,
	output logic                                jumped,
	input  skas_pkg::cmd_t                      cmd,
	output skas_pkg::status_t                   status
);

	localparam int EST_W = ADC_BITS + skas_pkg::FRAC_EST;
	localparam int ACC_W = skas_pkg::PROD_W;
	localparam logic [ADC_BITS-1:0] ADC_MAX = '1;
	localparam logic [EST_W-1:0] EST_MAX = {ADC_MAX, {skas_pkg::FRAC_EST{1'b0}}};
	localparam logic [EST_W:0] HALF_EST = (EST_W+1)'(1) << (skas_pkg::FRAC_EST - 1);
	localparam logic [ACC_W-1:0] HALF_BLEND = ACC_W'(1) << (skas_pkg::FRAC_EST - 1);
	localparam logic [ACC_W-1:0] HALF_GAIN = ACC_W'(1) << (skas_pkg::GAIN_FRAC - 1);

	logic [skas_pkg::NOISE_W-1:0]  q_noise_q, r_noise_q;
	logic [skas_pkg::THR_W-1:0]    thr_q;
	logic [skas_pkg::WEIGHT_W-1:0] w_q;

	logic [EST_W-1:0]              est_q;
	logic [skas_pkg::NOISE_W-1:0]  var_q;
	logic [skas_pkg::DIV_CNT_W-1:0] cnt_q;

	logic [ADC_BITS-1:0]           s_q;
	logic [EST_W-1:0]              old_q, mag_q, prior_q, corr_q;
	logic [skas_pkg::NOISE_W-1:0]  p_q;
	logic [skas_pkg::NOISE_W:0]    denom_q, rem_q;
	logic                          dzero_q, jump_q, neg_q;
	logic [skas_pkg::PROD_W-1:0]   prod_q;
	logic [ACC_W-1:0]              acc_q;
	logic [skas_pkg::GAIN_W-1:0]   quot_q;
	logic [skas_pkg::SAMPLE_W-1:0] filtered_q;
	logic                          jumped_q;

	logic [skas_pkg::ADC_BITS_MAX-1:0] sample_wide;
	logic [ADC_BITS-1:0]           s_in;
	logic [skas_pkg::NOISE_W:0]    p_sum;
	logic [skas_pkg::NOISE_W-1:0]  p_sat;
	logic [EST_W-1:0]              s_fx, diff_mag;
	logic [skas_pkg::CMP_W-1:0]    thr_fx;
	logic                          jump_c;
	logic [skas_pkg::WEIGHT_W:0]   wcomp;
	logic [skas_pkg::GAIN_W-1:0]   gain, gain_comp;
	logic [skas_pkg::MUL_A_W-1:0]  mul_a;
	logic [skas_pkg::MUL_B_W-1:0]  mul_b;
	logic [skas_pkg::PROD_W-1:0]   mul_p;
	logic [ACC_W-1:0]              blend_sum;
	logic                          nbit;
	logic [skas_pkg::NOISE_W+1:0]  rem_sh, rem_next;
	logic                          rem_ge;
	logic [ACC_W-1:0]              corr_sum;
	logic signed [EST_W+1:0]       prior_x, corr_x, nxt;
	logic [EST_W-1:0]              est_clamp;
	logic [EST_W:0]                rnd;
	logic [ADC_BITS:0]             rnd_cnt;
	logic [ADC_BITS-1:0]           fout;
	logic [skas_pkg::ADC_BITS_MAX-1:0] fout_wide;

	assign sample_wide = skas_pkg::ADC_BITS_MAX'(sample);
	assign s_in        = sample_wide[ADC_BITS-1:0];

	assign p_sum = {1'b0, var_q} + {1'b0, q_noise_q};
	assign p_sat = p_sum[skas_pkg::NOISE_W] ? '1 : p_sum[skas_pkg::NOISE_W-1:0];

	assign s_fx     = {s_q, {skas_pkg::FRAC_EST{1'b0}}};
	assign diff_mag = (old_q >= s_fx) ? (old_q - s_fx) : (s_fx - old_q);
	assign thr_fx   = skas_pkg::CMP_W'(thr_q) << skas_pkg::FRAC_EST;
	assign jump_c   = skas_pkg::CMP_W'(diff_mag) >= thr_fx;
	assign wcomp    = {1'b1, {skas_pkg::WEIGHT_W{1'b0}}} - {1'b0, w_q};

	assign gain      = dzero_q ? '0 : quot_q;
	assign gain_comp = skas_pkg::ONE_GAIN - gain;

	always_comb begin
		case (cmd.mul_sel)
			skas_pkg::MUL_OLD: begin
				mul_a = skas_pkg::MUL_A_W'(old_q);
				mul_b = skas_pkg::MUL_B_W'(wcomp);
			end
			skas_pkg::MUL_SW: begin
				mul_a = skas_pkg::MUL_A_W'(s_q);
				mul_b = skas_pkg::MUL_B_W'(w_q);
			end
			skas_pkg::MUL_GAIN: begin
				mul_a = skas_pkg::MUL_A_W'(mag_q);
				mul_b = gain;
			end
			skas_pkg::MUL_VAR: begin
				mul_a = p_q;
				mul_b = gain_comp;
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;

	assign blend_sum = acc_q + (prod_q << skas_pkg::FRAC_EST) + HALF_BLEND;

	// long division of P * 2^24 by P + R, one quotient bit per step
	assign nbit     = (cnt_q == skas_pkg::DIV_CNT_W'(skas_pkg::DIV_STEPS - 1)) ? p_q[0] : 1'b0;
	assign rem_sh   = {rem_q, nbit};
	assign rem_ge   = rem_sh >= {1'b0, denom_q};
	assign rem_next = rem_ge ? (rem_sh - {1'b0, denom_q}) : rem_sh;

	assign status.div_done = (cnt_q == '0);

	assign corr_sum = prod_q + HALF_GAIN;

	assign prior_x = $signed({2'b00, prior_q});
	assign corr_x  = $signed({2'b00, corr_q});
	assign nxt     = neg_q ? (prior_x - corr_x) : (prior_x + corr_x);

	always_comb begin
		if (nxt[EST_W+1]) begin
			est_clamp = '0;
		end else if (nxt > $signed({2'b00, EST_MAX})) begin
			est_clamp = EST_MAX;
		end else begin
			est_clamp = nxt[EST_W-1:0];
		end
	end

	assign rnd       = {1'b0, est_q} + HALF_EST;
	assign rnd_cnt   = rnd[EST_W:skas_pkg::FRAC_EST];
	assign fout      = rnd_cnt[ADC_BITS] ? ADC_MAX : rnd_cnt[ADC_BITS-1:0];
	assign fout_wide = skas_pkg::ADC_BITS_MAX'(fout);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_noise_q <= skas_pkg::PROCESS_NOISE_RST;
			r_noise_q <= skas_pkg::MEASUREMENT_NOISE_RST;
			thr_q     <= skas_pkg::JUMP_THRESHOLD_RST;
			w_q       <= skas_pkg::BLEND_WEIGHT_RST;
			est_q     <= '0;
			var_q     <= '0;
			cnt_q     <= '0;
		end else begin
			if (cfg_valid) begin
				case (skas_pkg::cfg_reg_t'(cfg_index))
					skas_pkg::REG_PROCESS_NOISE:     q_noise_q <= cfg_data[skas_pkg::NOISE_W-1:0];
					skas_pkg::REG_MEASUREMENT_NOISE: r_noise_q <= cfg_data[skas_pkg::NOISE_W-1:0];
					skas_pkg::REG_JUMP_THRESHOLD:    thr_q     <= cfg_data[skas_pkg::THR_W-1:0];
					skas_pkg::REG_BLEND_WEIGHT:      w_q       <= cfg_data[skas_pkg::WEIGHT_W-1:0];
					default: begin
					end
				endcase
			end
			if (cmd.prep) begin
				cnt_q <= skas_pkg::DIV_CNT_W'(skas_pkg::DIV_STEPS - 1);
			end else if (cmd.div_step && cnt_q != '0) begin
				cnt_q <= cnt_q - 1'b1;
			end
			if (cmd.commit) begin
				est_q <= est_clamp;
				var_q <= prod_q[skas_pkg::GAIN_FRAC+skas_pkg::NOISE_W-1:skas_pkg::GAIN_FRAC];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			s_q   <= s_in;
			old_q <= est_q;
			p_q   <= p_sat;
		end
		if (cmd.prep) begin
			denom_q <= {1'b0, p_q} + {1'b0, r_noise_q};
			dzero_q <= (p_q == '0) && (r_noise_q == '0);
			rem_q   <= {2'b00, p_q[skas_pkg::NOISE_W-1:1]};
			jump_q  <= jump_c;
			neg_q   <= old_q > s_fx;
			mag_q   <= diff_mag;
		end
		if (cmd.acc_load) begin
			acc_q <= prod_q;
		end
		if (cmd.mul_en) begin
			prod_q <= mul_p;
		end
		if (cmd.blend_add) begin
			prior_q <= jump_q ? blend_sum[EST_W+skas_pkg::FRAC_EST-1:skas_pkg::FRAC_EST] : old_q;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_next[skas_pkg::NOISE_W:0];
			quot_q <= {quot_q[skas_pkg::GAIN_W-2:0], rem_ge};
		end
		if (cmd.corr_load) begin
			corr_q <= corr_sum[EST_W+skas_pkg::GAIN_FRAC-1:skas_pkg::GAIN_FRAC];
		end
		if (cmd.out_load) begin
			filtered_q <= fout_wide[skas_pkg::SAMPLE_W-1:0];
			jumped_q   <= jump_q;
		end
	end

	assign filtered = filtered_q;
	assign jumped   = jumped_q;

	`SKAS_ASSERT_IMPL(a_est_in_range, 1'b1, est_q <= EST_MAX, "estimate beyond ADC range")
	`SKAS_ASSERT_IMPL(a_gain_in_range, cmd.mul_en && cmd.mul_sel == skas_pkg::MUL_GAIN, gain <= skas_pkg::ONE_GAIN, "gain above one")
	`SKAS_ASSERT_IMPL(a_div_rem_below_denom, cmd.div_step && !dzero_q, rem_next < {1'b0, denom_q}, "divider remainder not below denominator")

endmodule

### rtl/scalar_kalman_adc_smoother_core.sv
// Top level of the scalar Kalman ADC smoother
// One sample is processed at a time: a new sample is taken only after the previous
// one has passed the 25-step serial gain divider and been loaded for output.
// A finished result waits in its output register while the next sample is taken.
// Reset: estimate and variance clear to zero, noise, threshold and weight
// registers load their defaults, no result is pending.
module scalar_kalman_adc_smoother_core #(
	parameter int ADC_BITS = skas_pkg::ADC_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              sample_valid,
	output logic                              sample_stall,
	input  logic [skas_pkg::SAMPLE_W-1:0]     sample,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [skas_pkg::SAMPLE_W-1:0]     filtered,
	output logic                              jumped,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [skas_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [skas_pkg::CFG_DATA_W-1:0]   cfg_data
);

	skas_pkg::cmd_t    cmd;
	skas_pkg::status_t status;

	assign cfg_ready = 1'b1;

	skas_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.status       (status),
		.cmd          (cmd)
	);

	skas_datapath #(
		.ADC_BITS (ADC_BITS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.sample    (sample),
		.filtered  (filtered),
		.jumped    (jumped),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

### tb/scalar_kalman_adc_smoother_core_test.sv
// Self-checking testbench for the scalar Kalman ADC smoother core
module scalar_kalman_adc_smoother_core_test;

	typedef struct packed {
		logic [skas_pkg::SAMPLE_W-1:0] filtered;
		logic                          jumped;
	} smoothed_t;

	localparam int          DRAIN_CYCLES = 40;
	localparam int          LONG_HOLD    = 300;
	localparam logic [63:0] EST_LIMIT    =
		((64'd1 << skas_pkg::ADC_BITS_DEF) - 64'd1) << skas_pkg::FRAC_EST;
	localparam logic [63:0] ADC_LIMIT    = (64'd1 << skas_pkg::ADC_BITS_DEF) - 64'd1;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            sample_valid = 1'b0;
	logic                            sample_stall;
	logic [skas_pkg::SAMPLE_W-1:0]   sample = '0;
	logic                            result_valid;
	logic                            result_stall = 1'b0;
	logic [skas_pkg::SAMPLE_W-1:0]   filtered;
	logic                            jumped;
	logic                            cfg_valid = 1'b0;
	logic                            cfg_ready;
	logic [skas_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
	logic [skas_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	logic [skas_pkg::NOISE_W-1:0]  process_noise_cfg     = skas_pkg::PROCESS_NOISE_RST;
	logic [skas_pkg::NOISE_W-1:0]  measurement_noise_cfg = skas_pkg::MEASUREMENT_NOISE_RST;
	logic [skas_pkg::THR_W-1:0]    jump_thr_cfg          = skas_pkg::JUMP_THRESHOLD_RST;
	logic [skas_pkg::WEIGHT_W-1:0] blend_w_cfg           = skas_pkg::BLEND_WEIGHT_RST;
	logic [skas_pkg::ADC_BITS_DEF+15:0] est_fx = '0;
	logic [skas_pkg::NOISE_W-1:0]  var_fx = '0;

	smoothed_t expected_outputs[$];
	smoothed_t head;
	smoothed_t predicted;

	bit calm = 1'b0;
	int holds_asked = 0;
	int holds_served = 0;
	int hold_left = 0;
	int n_errors = 0;
	int n_samples = 0;
	int n_results = 0;
	int n_jumps = 0;
	int n_cfg_writes = 0;
	int n_input_stalls = 0;

	scalar_kalman_adc_smoother_core i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample_valid(sample_valid),
		.sample_stall(sample_stall),
		.sample(sample),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.filtered(filtered),
		.jumped(jumped),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	function automatic smoothed_t kalman_predict(input logic [skas_pkg::SAMPLE_W-1:0] value);
		logic [63:0] s_fx, old, diff_mag, prior, p, denom, gain, corr, nxt, fout;
		logic        jump, below;
		smoothed_t   r;
		s_fx = (64'(value) & ADC_LIMIT) << skas_pkg::FRAC_EST;
		old = 64'(est_fx);
		below = s_fx < old;
		diff_mag = below ? old - s_fx : s_fx - old;
		jump = diff_mag >= (64'(jump_thr_cfg) << skas_pkg::FRAC_EST);
		if (jump)
			prior = (s_fx * 64'(blend_w_cfg) + old * (64'd65536 - 64'(blend_w_cfg))
				+ 64'd32768) >> 16;
		else
			prior = old;
		p = 64'(var_fx) + 64'(process_noise_cfg);
		if (p > 64'hFFFF_FFFF)
			p = 64'hFFFF_FFFF;
		denom = p + 64'(measurement_noise_cfg);
		gain = (denom == 64'd0) ? 64'd0 : (p << skas_pkg::GAIN_FRAC) / denom;
		corr = (gain * diff_mag + (64'd1 << (skas_pkg::GAIN_FRAC - 1))) >> skas_pkg::GAIN_FRAC;
		if (below)
			nxt = (corr > prior) ? 64'd0 : prior - corr;
		else
			nxt = prior + corr;
		if (nxt > EST_LIMIT)
			nxt = EST_LIMIT;
		est_fx = nxt[skas_pkg::ADC_BITS_DEF+15:0];
		var_fx = 32'((((64'd1 << skas_pkg::GAIN_FRAC) - gain) * p) >> skas_pkg::GAIN_FRAC);
		fout = (nxt + (64'd1 << (skas_pkg::FRAC_EST - 1))) >> skas_pkg::FRAC_EST;
		if (fout > ADC_LIMIT)
			fout = ADC_LIMIT;
		r.filtered = fout[skas_pkg::SAMPLE_W-1:0];
		r.jumped = jump;
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		if (n_errors < 50)
			$display("%0t mismatch on %s: got %0d, expected %0d", $time, what, got, want);
		n_errors++;
	endtask

	always @(posedge clk) begin
		if (arst_n && sample_valid) begin
			if (sample_stall) begin
				n_input_stalls++;
			end else begin
				predicted = kalman_predict(sample);
				expected_outputs.push_back(predicted);
				n_samples++;
				if (predicted.jumped)
					n_jumps++;
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			n_results++;
			if (expected_outputs.size() == 0) begin
				report_mismatch("unrequested result", 32'(filtered), 32'd0);
			end else begin
				head = expected_outputs.pop_front();
				if (filtered !== head.filtered)
					report_mismatch("filtered", 32'(filtered), 32'(head.filtered));
				if (jumped !== head.jumped)
					report_mismatch("jumped", 32'(jumped), 32'(head.jumped));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if (holds_served != holds_asked) begin
				holds_served <= holds_asked;
				hold_left <= LONG_HOLD;
				result_stall <= 1'b1;
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_stall <= 1'b1;
			end else if (!calm && $urandom_range(99) < 26) begin
				result_stall <= 1'b1;
				if ($urandom_range(7) == 0)
					hold_left <= $urandom_range(1, 40);
			end else begin
				result_stall <= 1'b0;
			end
		end
	end

	task automatic send_sample(input logic [skas_pkg::SAMPLE_W-1:0] value);
		if (!calm && $urandom_range(99) < 26) begin
			sample_valid <= 1'b0;
			repeat ($urandom_range(1, 60)) @(posedge clk);
		end
		sample <= value;
		sample_valid <= 1'b1;
		@(posedge clk);
		while (sample_stall) @(posedge clk);
	endtask

	function automatic logic [skas_pkg::SAMPLE_W-1:0] near_level(input int level,
			input int span);
		int v;
		v = level + int'($urandom_range(0, 2 * span)) - span;
		if (v < 0)
			v = 0;
		if (v > 4095)
			v = 4095;
		return skas_pkg::SAMPLE_W'(v);
	endfunction

	task automatic send_samples(input int count);
		int level;
		int roll;
		level = $urandom_range(4095);
		repeat (count) begin
			roll = $urandom_range(99);
			if (roll < 8)
				level = $urandom_range(4095);
			if (roll < 85)
				send_sample(near_level(level, $urandom_range(0, 48)));
			else
				send_sample(skas_pkg::SAMPLE_W'($urandom_range(4095)));
		end
		sample_valid <= 1'b0;
	endtask

	task automatic wait_idle();
		@(posedge clk);
		while (expected_outputs.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic cfg_write(input skas_pkg::cfg_reg_t idx,
			input logic [skas_pkg::CFG_DATA_W-1:0] data);
		cfg_index <= idx;
		cfg_data <= data;
		cfg_valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		case (idx)
			skas_pkg::REG_PROCESS_NOISE:     process_noise_cfg = data;
			skas_pkg::REG_MEASUREMENT_NOISE: measurement_noise_cfg = data;
			skas_pkg::REG_JUMP_THRESHOLD:    jump_thr_cfg = data[skas_pkg::THR_W-1:0];
			skas_pkg::REG_BLEND_WEIGHT:      blend_w_cfg = data[skas_pkg::WEIGHT_W-1:0];
			default: ;
		endcase
		n_cfg_writes++;
	endtask

	task automatic set_config(input logic [31:0] q, input logic [31:0] r,
			input logic [31:0] thr, input logic [31:0] w);
		wait_idle();
		cfg_write(skas_pkg::REG_PROCESS_NOISE, q);
		cfg_write(skas_pkg::REG_MEASUREMENT_NOISE, r);
		cfg_write(skas_pkg::REG_JUMP_THRESHOLD, thr);
		cfg_write(skas_pkg::REG_BLEND_WEIGHT, w);
		cfg_valid <= 1'b0;
	endtask

	task automatic test_reset_defaults();
		send_sample(12'd0);
		send_sample(12'd10);
		send_sample(12'd9);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd2048);
		sample_valid <= 1'b0;
	endtask

	task automatic test_register_extremes();
		set_config(32'hFFFF_FFFF, 32'd1, 32'd0, 32'd65535);
		send_sample(12'd4095);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd1);
		sample_valid <= 1'b0;
		set_config(32'd0, 32'hFFFF_FFFF, 32'd4095, 32'd0);
		send_sample(12'd0);
		send_sample(12'd4095);
		send_sample(12'd2048);
		sample_valid <= 1'b0;
		set_config(32'd0, 32'd1, 32'hFFFF_FFFF, 32'h8000);
		send_sample(12'd4095);
		send_sample(12'd0);
		sample_valid <= 1'b0;
	endtask

	task automatic test_output_backpressure();
		set_config(32'd1678, 32'd83886080, 32'd10, 32'd25035);
		calm = 1'b1;
		holds_asked++;
		send_samples(12);
		calm = 1'b0;
	endtask

	task automatic test_drain_pause();
		send_samples(15);
		@(posedge clk);
		while (expected_outputs.size() != 0) @(posedge clk);
		send_samples(15);
	endtask

	task automatic test_random_settings();
		logic [31:0] q, r, thr, w;
		for (int ph = 0; ph < 7; ph++) begin
			case ($urandom_range(3))
				0: q = 32'd0;
				1: q = 32'hFFFF_FFFF;
				2: q = $urandom_range(50000);
				default: q = $urandom;
			endcase
			case ($urandom_range(3))
				0: r = 32'd1;
				1: r = 32'hFFFF_FFFF;
				2: r = $urandom_range(1, 32'h0400_0000);
				default: r = $urandom;
			endcase
			if (r == 32'd0)
				r = 32'd1;
			case ($urandom_range(3))
				0: thr = 32'd0;
				1: thr = 32'd4095;
				2: thr = $urandom_range(1, 60);
				default: thr = $urandom_range(4095);
			endcase
			case ($urandom_range(3))
				0: w = 32'd0;
				1: w = 32'd65535;
				2: w = 32'h8000;
				default: w = $urandom_range(65535);
			endcase
			thr = ($urandom & 32'hFFFF_F000) | thr;
			w = ($urandom & 32'hFFFF_0000) | w;
			set_config(q, r, thr, w);
			calm = (ph == 3);
			send_samples((ph == 3) ? 150 : 200);
		end
		calm = 1'b0;
	endtask

	initial begin
		#18000000;
		$display("** scalar_kalman_adc_smoother_core: FAILED **");
		$finish;
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_register_extremes();
		test_output_backpressure();
		test_drain_pause();
		test_random_settings();
		wait_idle();
		$display("%0d samples checked against %0d results, %0d with jump blend",
			n_samples, n_results, n_jumps);
		$display("%0d register writes, %0d cycles with the sample request held off",
			n_cfg_writes, n_input_stalls);
		if (n_errors == 0)
			$display("** scalar_kalman_adc_smoother_core: PASSED **");
		else
			$display("** scalar_kalman_adc_smoother_core: FAILED **");
		$finish;
	end

endmodule
